// ===== src/pfgb_pkg.sv =====
// Shared constants and types for the page framebuffer glyph blitter.
`default_nettype none

package pfgb_pkg;

    localparam int DISP_WIDTH  = 128;
    localparam int DISP_HEIGHT = 56;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_ROWS  = 7;

    localparam int NUM_PAGES   = (DISP_HEIGHT + 7) / 8;
    localparam int STORE_BYTES = NUM_PAGES * DISP_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PAGE_W      = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int COL_W       = $clog2(DISP_WIDTH);
    localparam int CIDX_W      = $clog2(GLYPH_COLS);

    localparam int TYPE_W      = 2;
    localparam int POS_W       = 10;
    localparam int GLYPH_W     = 7;
    localparam int SCALE_W     = 4;
    localparam int RADDR_W     = 10;
    localparam int BYTE_W      = 8;
    localparam int ROW_W       = POS_W + 1;

    typedef enum logic [TYPE_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_PIXEL = 2'd1,
        REQ_GLYPH = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef logic signed [ROW_W-1:0] row_t;

    typedef struct packed {
        logic [GLYPH_ROWS-1:0] lit;
        row_t [GLYPH_ROWS-1:0] lo;
        row_t [GLYPH_ROWS-1:0] hi;
    } span_t;

    typedef struct packed {
        logic              pend;
        logic              set;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] mask;
    } rmw_t;

endpackage

`default_nettype wire

// ===== src/pfgb_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module pfgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 896
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== src/pfgb_mask.sv =====
// Byte mask of glyph pixels that fall in one page of one screen column.
`default_nettype none

module pfgb_mask (
    input  wire logic [pfgb_pkg::PAGE_W-1:0] page,
    input  wire pfgb_pkg::span_t             span,
    output logic      [pfgb_pkg::BYTE_W-1:0] mask
);

    always_comb
    begin
        pfgb_pkg::row_t prow;
        logic           hit;
        for (int b = 0; b < pfgb_pkg::BYTE_W; b++)
        begin
            prow = pfgb_pkg::row_t'({page, 3'(b)});
            hit  = 1'b0;
            for (int r = 0; r < pfgb_pkg::GLYPH_ROWS; r++)
            begin
                hit = hit | (span.lit[r] && (prow >= span.lo[r]) && (prow <= span.hi[r]));
            end
            mask[b] = hit && (prow < pfgb_pkg::row_t'(pfgb_pkg::DISP_HEIGHT));
        end
    end

endmodule

`default_nettype wire

// ===== src/page_framebuffer_glyph_blitter.sv =====
// Top level: command sequencer around the framebuffer RAM with read-modify-write.
//
// The framebuffer lives in one RAM of 896 bytes with a registered read, and
// every command goes through its single write port and single read port. After reset
// the block zeroes the RAM before it takes the first word. A clear rewrites every
// byte, and a glyph blit steps over each off-screen column and does one
// read-modify-write per page (7 pages) for each on-screen column, over 5*scale
// columns, and ends early once it passes the right edge. Each page of a glyph
// column is one read-modify-write, overlapped so that one byte is updated per cycle.
// A new word is taken only when the previous command has finished, while its result
// may still wait in the output register.
`default_nettype none

module page_framebuffer_glyph_blitter (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic        [pfgb_pkg::TYPE_W-1:0]  req_type,
    input  wire logic signed [pfgb_pkg::POS_W-1:0]   pos_x,
    input  wire logic signed [pfgb_pkg::POS_W-1:0]   pos_y,
    input  wire logic                                pixel_on,
    input  wire logic        [pfgb_pkg::GLYPH_W-1:0] glyph_col0,
    input  wire logic        [pfgb_pkg::GLYPH_W-1:0] glyph_col1,
    input  wire logic        [pfgb_pkg::GLYPH_W-1:0] glyph_col2,
    input  wire logic        [pfgb_pkg::GLYPH_W-1:0] glyph_col3,
    input  wire logic        [pfgb_pkg::GLYPH_W-1:0] glyph_col4,
    input  wire logic        [pfgb_pkg::SCALE_W-1:0] glyph_scale,
    input  wire logic        [pfgb_pkg::RADDR_W-1:0] read_address,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic             [pfgb_pkg::BYTE_W-1:0]  read_data,
    output logic             [pfgb_pkg::TYPE_W-1:0]  done_type
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_PIXEL,
        ST_GLYPH,
        ST_READ,
        ST_RWAIT,
        ST_FIN
    } state_t;

    localparam int AW = pfgb_pkg::ADDR_W;
    localparam int PW = pfgb_pkg::PAGE_W;
    localparam int BW = pfgb_pkg::BYTE_W;

    state_t                         state_reg,      state_next;
    logic [AW-1:0]                  sweep_reg,      sweep_next;
    pfgb_pkg::req_t                 type_reg,       type_next;
    pfgb_pkg::row_t                 x_reg,          x_next;
    pfgb_pkg::row_t                 y_reg,          y_next;
    logic                           on_reg,         on_next;
    logic [pfgb_pkg::GLYPH_W-1:0]   cols_reg [pfgb_pkg::GLYPH_COLS];
    logic [pfgb_pkg::GLYPH_W-1:0]   cols_next [pfgb_pkg::GLYPH_COLS];
    logic [pfgb_pkg::SCALE_W-1:0]   scale_reg,      scale_next;
    logic [pfgb_pkg::RADDR_W-1:0]   raddr_reg,      raddr_next;
    pfgb_pkg::span_t                span_reg,       span_next;
    logic [PW-1:0]                  page_reg,       page_next;
    logic [pfgb_pkg::CIDX_W-1:0]    c_reg,          c_next;
    logic [pfgb_pkg::SCALE_W-1:0]   sx_reg,         sx_next;
    pfgb_pkg::rmw_t                 rmw_reg,        rmw_next;
    logic [BW-1:0]                  result_reg,     result_next;
    logic                           out_valid_reg,  out_valid_next;
    logic [BW-1:0]                  read_data_reg,  read_data_next;
    pfgb_pkg::req_t                 done_type_reg,  done_type_next;

    logic                           accept;
    logic                           ram_wr_en;
    logic [AW-1:0]                  ram_wr_addr;
    logic [BW-1:0]                  ram_wr_data;
    logic                           ram_rd_en;
    logic [AW-1:0]                  ram_rd_addr;
    logic [BW-1:0]                  ram_rd_data;
    pfgb_pkg::span_t                span_cur;
    logic [BW-1:0]                  glyph_mask;
    logic [AW-1:0]                  glyph_addr;
    logic [AW-1:0]                  pixel_addr;
    logic                           pixel_ok;

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign done_type = done_type_reg;

    always_comb
    begin
        span_cur     = span_reg;
        span_cur.lit = cols_reg[c_reg];
    end

    pfgb_mask u_mask (
        .page (page_reg),
        .span (span_cur),
        .mask (glyph_mask)
    );

    assign glyph_addr = AW'(page_reg) * AW'(pfgb_pkg::DISP_WIDTH)
                      + AW'(x_reg[pfgb_pkg::COL_W-1:0]);
    assign pixel_addr = AW'(y_reg[PW+2:3]) * AW'(pfgb_pkg::DISP_WIDTH)
                      + AW'(x_reg[pfgb_pkg::COL_W-1:0]);
    assign pixel_ok   = !x_reg[pfgb_pkg::ROW_W-1]
                      && (x_reg < pfgb_pkg::row_t'(pfgb_pkg::DISP_WIDTH))
                      && !y_reg[pfgb_pkg::ROW_W-1]
                      && (y_reg < pfgb_pkg::row_t'(pfgb_pkg::DISP_HEIGHT));

    pfgb_ram #(
        .WIDTH (BW),
        .DEPTH (pfgb_pkg::STORE_BYTES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Second half of the read-modify-write; the sweeps of clear and init never overlap it.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = sweep_reg;
        ram_wr_data = '0;
        if (rmw_reg.pend)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = rmw_reg.addr;
            ram_wr_data = rmw_reg.set ? (ram_rd_data | rmw_reg.mask)
                                      : (ram_rd_data & ~rmw_reg.mask);
        end
        else if ((state_reg == ST_CLEAR) || (state_reg == ST_INIT))
        begin
            ram_wr_en = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        type_next      = type_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        on_next        = on_reg;
        cols_next      = cols_reg;
        scale_next     = scale_reg;
        raddr_next     = raddr_reg;
        span_next      = span_reg;
        page_next      = page_reg;
        c_next         = c_reg;
        sx_next        = sx_reg;
        rmw_next       = rmw_reg;
        rmw_next.pend  = 1'b0;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;
        read_data_next = read_data_reg;
        done_type_next = done_type_reg;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = glyph_addr;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(pfgb_pkg::STORE_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    type_next    = pfgb_pkg::req_t'(req_type);
                    x_next       = pfgb_pkg::row_t'(pos_x);
                    y_next       = pfgb_pkg::row_t'(pos_y);
                    on_next      = pixel_on;
                    cols_next[0] = glyph_col0;
                    cols_next[1] = glyph_col1;
                    cols_next[2] = glyph_col2;
                    cols_next[3] = glyph_col3;
                    cols_next[4] = glyph_col4;
                    scale_next   = glyph_scale;
                    raddr_next   = read_address;
                    page_next    = '0;
                    c_next       = '0;
                    sx_next      = '0;
                    sweep_next   = '0;
                    result_next  = '0;
                    for (int r = 0; r < pfgb_pkg::GLYPH_ROWS; r++)
                    begin
                        span_next.lo[r] = pfgb_pkg::row_t'(pos_y)
                            + pfgb_pkg::row_t'(pfgb_pkg::ROW_W'(r)
                                               * pfgb_pkg::ROW_W'(glyph_scale));
                        span_next.hi[r] = span_next.lo[r]
                            + pfgb_pkg::row_t'(glyph_scale) - pfgb_pkg::row_t'(1);
                    end
                    unique case (pfgb_pkg::req_t'(req_type))
                        pfgb_pkg::REQ_CLEAR: state_next = ST_CLEAR;
                        pfgb_pkg::REQ_PIXEL: state_next = ST_PIXEL;
                        pfgb_pkg::REQ_GLYPH: state_next = (glyph_scale == '0) ? ST_FIN
                                                                                : ST_GLYPH;
                        pfgb_pkg::REQ_READ:  state_next = ST_READ;
                        default:             state_next = ST_FIN;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                sweep_next = sweep_reg + AW'(1);
                if (sweep_reg == AW'(pfgb_pkg::STORE_BYTES - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_PIXEL:
            begin
                if (pixel_ok)
                begin
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = pixel_addr;
                    rmw_next.pend = 1'b1;
                    rmw_next.set  = on_reg;
                    rmw_next.addr = pixel_addr;
                    rmw_next.mask = BW'(1) << y_reg[2:0];
                end
                state_next = ST_FIN;
            end
            ST_GLYPH:
            begin
                if (x_reg >= pfgb_pkg::row_t'(pfgb_pkg::DISP_WIDTH))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    if (!x_reg[pfgb_pkg::ROW_W-1])
                    begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = glyph_addr;
                        rmw_next.pend = |glyph_mask;
                        rmw_next.set  = 1'b1;
                        rmw_next.addr = glyph_addr;
                        rmw_next.mask = glyph_mask;
                    end
                    if (x_reg[pfgb_pkg::ROW_W-1]
                        || (page_reg == PW'(pfgb_pkg::NUM_PAGES - 1)))
                    begin
                        page_next = '0;
                        x_next    = x_reg + pfgb_pkg::row_t'(1);
                        if (sx_reg == scale_reg - pfgb_pkg::SCALE_W'(1))
                        begin
                            sx_next = '0;
                            if (c_reg == pfgb_pkg::CIDX_W'(pfgb_pkg::GLYPH_COLS - 1))
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                c_next = c_reg + pfgb_pkg::CIDX_W'(1);
                            end
                        end
                        else
                        begin
                            sx_next = sx_reg + pfgb_pkg::SCALE_W'(1);
                        end
                    end
                    else
                    begin
                        page_next = page_reg + PW'(1);
                    end
                end
            end
            ST_READ:
            begin
                ram_rd_addr = AW'(raddr_reg);
                if (32'(raddr_reg) < pfgb_pkg::STORE_BYTES)
                begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_RWAIT;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_RWAIT:
            begin
                result_next = ram_rd_data;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    read_data_next = result_reg;
                    done_type_next = type_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            type_reg      <= pfgb_pkg::REQ_CLEAR;
            x_reg         <= '0;
            y_reg         <= '0;
            on_reg        <= 1'b0;
            cols_reg      <= '{default: '0};
            scale_reg     <= '0;
            raddr_reg     <= '0;
            span_reg      <= '0;
            page_reg      <= '0;
            c_reg         <= '0;
            sx_reg        <= '0;
            rmw_reg       <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            read_data_reg <= '0;
            done_type_reg <= pfgb_pkg::REQ_CLEAR;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            type_reg      <= type_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            on_reg        <= on_next;
            cols_reg      <= cols_next;
            scale_reg     <= scale_next;
            raddr_reg     <= raddr_next;
            span_reg      <= span_next;
            page_reg      <= page_next;
            c_reg         <= c_next;
            sx_reg        <= sx_next;
            rmw_reg       <= rmw_next;
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
            read_data_reg <= read_data_next;
            done_type_reg <= done_type_next;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the page framebuffer glyph blitter.

module tb_top;
    import pfgb_pkg::*;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int RANDOM_WORDS = 900;
    localparam int DRAIN_CYCLES = 100;

    typedef logic [GLYPH_COLS-1:0][GLYPH_W-1:0] glyph_t;

    typedef struct packed {
        req_t                      kind;
        logic signed [POS_W-1:0]   px;
        logic signed [POS_W-1:0]   py;
        logic                      on;
        glyph_t                    cols;
        logic        [SCALE_W-1:0] scale;
        logic        [RADDR_W-1:0] addr;
    } cmd_t;

    typedef struct {
        logic [BYTE_W-1:0] data;
        req_t              kind;
    } done_t;

    class fb_shadow;
        logic [BYTE_W-1:0] pixels [STORE_BYTES];
        done_t             due_results [$];
        int                errors;
        int                checked;
        int                nonzero_reads;
        int                per_kind [4];

        function new();
            foreach (pixels[i]) pixels[i] = '0;
            errors        = 0;
            checked       = 0;
            nonzero_reads = 0;
            foreach (per_kind[i]) per_kind[i] = 0;
        endfunction

        function void plot(int x, int y, bit on);
            int addr;
            if (x < 0 || x >= DISP_WIDTH || y < 0 || y >= DISP_HEIGHT) return;
            addr = (y / 8) * DISP_WIDTH + x;
            pixels[addr][y % 8] = on;
        endfunction

        function void take_command(cmd_t c);
            done_t d;
            int    ox;
            int    oy;
            int    sc;
            ox     = $signed(c.px);
            oy     = $signed(c.py);
            sc     = c.scale;
            d.data = '0;
            d.kind = c.kind;
            per_kind[c.kind]++;
            case (c.kind)
                REQ_CLEAR: foreach (pixels[i]) pixels[i] = '0;
                REQ_PIXEL: plot(ox, oy, c.on);
                REQ_GLYPH:
                begin
                    for (int col = 0; col < GLYPH_COLS; col++)
                        for (int row = 0; row < GLYPH_ROWS; row++)
                            if (c.cols[col][row])
                                for (int sy = 0; sy < sc; sy++)
                                    for (int sx = 0; sx < sc; sx++)
                                        plot(ox + col * sc + sx, oy + row * sc + sy, 1'b1);
                end
                default:
                begin
                    if (c.addr < STORE_BYTES) d.data = pixels[c.addr];
                    if (d.data != 0) nonzero_reads++;
                end
            endcase
            due_results.push_back(d);
        endfunction

        function void match_result(logic [BYTE_W-1:0] data, logic [TYPE_W-1:0] kind);
            done_t d;
            if (due_results.size() == 0)
            begin
                $error("Result word with nothing expected: read_data %0h, done_type %0d",
                       data, kind);
                errors++;
                return;
            end
            d = due_results.pop_front();
            checked++;
            if (data !== d.data)
            begin
                $error("read_data mismatch: expected %0h, actual %0h", d.data, data);
                errors++;
            end
            if (kind !== d.kind)
            begin
                $error("done_type mismatch: expected %0d, actual %0d", d.kind, kind);
                errors++;
            end
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic        [TYPE_W-1:0]    req_type = '0;
    logic signed [POS_W-1:0]     pos_x = '0;
    logic signed [POS_W-1:0]     pos_y = '0;
    logic                        pixel_on = 1'b0;
    logic        [GLYPH_W-1:0]   glyph_col0 = '0;
    logic        [GLYPH_W-1:0]   glyph_col1 = '0;
    logic        [GLYPH_W-1:0]   glyph_col2 = '0;
    logic        [GLYPH_W-1:0]   glyph_col3 = '0;
    logic        [GLYPH_W-1:0]   glyph_col4 = '0;
    logic        [SCALE_W-1:0]   glyph_scale = '0;
    logic        [RADDR_W-1:0]   read_address = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic        [BYTE_W-1:0]    read_data;
    logic        [TYPE_W-1:0]    done_type;

    fb_shadow shadow = new();
    int       cycle_count = 0;
    int       burst_left = 0;
    int       stall_left = 0;
    int       stall_mode = 0;

    page_framebuffer_glyph_blitter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pixel_on     (pixel_on),
        .glyph_col0   (glyph_col0),
        .glyph_col1   (glyph_col1),
        .glyph_col2   (glyph_col2),
        .glyph_col3   (glyph_col3),
        .glyph_col4   (glyph_col4),
        .glyph_scale  (glyph_scale),
        .read_address (read_address),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_data    (read_data),
        .done_type    (done_type)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            shadow.match_result(read_data, done_type);
    end

    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(8, 60);
        end
        stall_left--;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic cmd_t blank_cmd(req_t kind);
        cmd_t c;
        c.kind  = kind;
        c.px    = POS_W'($urandom);
        c.py    = POS_W'($urandom);
        c.on    = 1'($urandom);
        c.cols  = (GLYPH_COLS * GLYPH_W)'({$urandom, $urandom});
        c.scale = SCALE_W'($urandom);
        c.addr  = RADDR_W'($urandom);
        return c;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(cmd_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_type     <= c.kind;
        pos_x        <= c.px;
        pos_y        <= c.py;
        pixel_on     <= c.on;
        glyph_col0   <= c.cols[0];
        glyph_col1   <= c.cols[1];
        glyph_col2   <= c.cols[2];
        glyph_col3   <= c.cols[3];
        glyph_col4   <= c.cols[4];
        glyph_scale  <= c.scale;
        read_address <= c.addr;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        shadow.take_command(c);
        @(negedge clk);
    endtask

    task automatic do_pixel(input int x, input int y, input bit on);
        cmd_t c;
        c    = blank_cmd(REQ_PIXEL);
        c.px = POS_W'(x);
        c.py = POS_W'(y);
        c.on = on;
        send_word(c);
    endtask

    task automatic do_glyph(input int x, input int y, input glyph_t cols, input int scale);
        cmd_t c;
        c       = blank_cmd(REQ_GLYPH);
        c.px    = POS_W'(x);
        c.py    = POS_W'(y);
        c.cols  = cols;
        c.scale = SCALE_W'(scale);
        send_word(c);
    endtask

    task automatic do_read(input int addr);
        cmd_t c;
        c      = blank_cmd(REQ_READ);
        c.addr = RADDR_W'(addr);
        send_word(c);
    endtask

    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
            c = blank_cmd(REQ_CLEAR);
        else if (pick < 28)
        begin
            c = blank_cmd(REQ_PIXEL);
            if ($urandom_range(0, 9) != 0)
            begin
                c.px = POS_W'(int'($urandom_range(0, 139)) - 6);
                c.py = POS_W'(int'($urandom_range(0, 67)) - 6);
            end
        end
        else if (pick < 62)
        begin
            c = blank_cmd(REQ_GLYPH);
            if ($urandom_range(0, 9) != 0)
            begin
                c.px = POS_W'(int'($urandom_range(0, 170)) - 40);
                c.py = POS_W'(int'($urandom_range(0, 100)) - 40);
            end
            if ($urandom_range(0, 9) < 8)
                c.scale = SCALE_W'($urandom_range(0, 4));
        end
        else
        begin
            c = blank_cmd(REQ_READ);
            if ($urandom_range(0, 9) != 0)
                c.addr = RADDR_W'($urandom_range(0, STORE_BYTES - 1));
        end
        return c;
    endfunction

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Store is all zero after reset, and reads past its end return zero.
        do_read(0);
        do_read(STORE_BYTES - 1);
        do_read(STORE_BYTES);
        do_read(1023);
        // Corner pixels, then pixels just off the left, right and bottom edges and one far off, which must be dropped.
        do_pixel(0, 0, 1'b1);
        do_pixel(DISP_WIDTH - 1, DISP_HEIGHT - 1, 1'b1);
        do_pixel(-1, 0, 1'b1);
        do_pixel(DISP_WIDTH, 3, 1'b1);
        do_pixel(5, DISP_HEIGHT, 1'b1);
        do_pixel(-512, 511, 1'b1);
        do_read(0);
        do_read(STORE_BYTES - 1);
        do_glyph(0, 0, '1, 1);
        do_read(4);
        do_pixel(0, 0, 1'b0);
        do_read(0);
        // A glyph at scale zero leaves the store alone.
        do_glyph(10, 10, '1, 0);
        do_read(DISP_WIDTH + 10);
        // Glyphs clipped at the right, bottom, top and left edges.
        do_glyph(120, 50, 35'h5_5AA5_5A5A, 3);
        do_glyph(-3, -4, 35'h2_A55A_A5A5, 2);
        do_glyph(-512, -512, '1, 15);
        do_glyph(100, 20, 35'h7_0F0F_0F0F, 15);
        do_read(3 * DISP_WIDTH + 105);
        send_word(blank_cmd(REQ_CLEAR));
        do_read(STORE_BYTES - 1);
        do_glyph(0, 0, 35'h1_2345_6789, 15);
        do_read(2 * DISP_WIDTH + 30);

        repeat (RANDOM_WORDS) send_word(random_command());
        in_valid <= 1'b0;

        while (shadow.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d clears, %0d pixel writes, %0d glyph blits and %0d reads.",
                 shadow.per_kind[REQ_CLEAR], shadow.per_kind[REQ_PIXEL],
                 shadow.per_kind[REQ_GLYPH], shadow.per_kind[REQ_READ]);
        $display("Checked %0d result words; %0d reads returned a nonzero byte.",
                 shadow.checked, shadow.nonzero_reads);
        if (shadow.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
